### rtl/core/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// shared types and constants of the terrain step cost grader
// ----------------------------------------------------------------------------
package tsc_pkg;

   localparam int HEIGHT_W   = 16;
   localparam int ENTRY_W    = 17;   // valid bit over a height
   localparam int LIMIT_W    = 16;
   localparam int WEIGHT_W   = 16;
   localparam int SIZE_W     = 9;
   localparam int COST_W     = 24;
   localparam int FACTOR_W   = 8;
   localparam int SCALED_W   = WEIGHT_W + FACTOR_W;
   localparam int FRAC_W     = 16;
   localparam int QUOT_W     = FRAC_W + 1;
   localparam int PROD_W     = SCALED_W + QUOT_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int WIN_N      = 9;
   localparam int WIN_IDX_W  = 4;
   localparam int WIN_CENTER = 4;
   localparam int DIV_CNT_W  = 4;

   localparam logic [FACTOR_W-1:0] BLOCK_FACTOR   = 8'd255;
   localparam logic [FACTOR_W-1:0] PARTIAL_FACTOR = 8'd200;

   localparam logic OP_CELL  = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RISE_LIMIT  = 3'd0,
      CSR_DROP_LIMIT  = 3'd1,
      CSR_STEP_WEIGHT = 3'd2,
      CSR_COLS_IN_USE = 3'd3,
      CSR_ROWS_IN_USE = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SHIFT,
      ST_SCAN,
      ST_LIMIT,
      ST_DIV,
      ST_MULT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                operation;
      logic [HEIGHT_W-1:0] cell_height;
      logic                cell_occupied;
   } req_payload_type;

   typedef struct packed {
      logic                updated;
      logic [HEIGHT_W-1:0] step_rise;
      logic                blocked;
      logic [COST_W-1:0]   cost_add;
      logic                frame_end;
   } rsp_payload_type;

   typedef struct packed {
      logic has_mid;     // a line above exists
      logic has_top;     // two lines above exist
      logic first_col;   // column zero position
      logic emit;        // this beat yields a result
      logic last;        // result closes the frame
   } item_ctl_type;

endpackage

### rtl/core/tsc_req_if.sv
// ----------------------------------------------------------------------------
// tsc_req_if
// grid cell channel, valid/ready with one cell per beat
// ----------------------------------------------------------------------------
interface tsc_req_if import tsc_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/tsc_rsp_if.sv
// ----------------------------------------------------------------------------
// tsc_rsp_if
// graded cell channel, valid/ready with one result per beat
// ----------------------------------------------------------------------------
interface tsc_rsp_if import tsc_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/terrain_step_cost_3x3.sv
// ----------------------------------------------------------------------------
// terrain_step_cost_3x3
// step height and step cost grading of an elevation grid over a 3x3 window
// ----------------------------------------------------------------------------
//  channel    direction  beat contents
//  req_chan   in         operation, cell_height, cell_occupied (raster order)
//  rsp_chan   out        updated, step_rise, blocked, cost_add, frame_end
//  csr_*      in         write enable, register index, 16-bit write data
//
//  a graded cell is finished before the next accept: the 16-step
//  restoring divider runs twice (rise quotient, then drop quotient) after the
//  neighbor scan over the nine window entries; a blocked or empty center skips
//  the divider, a beat with no result skips the scan, an early flush stays idle
//  reset is synchronous; line stores are not cleared, the window and counters are
//  a finished result sits in the output register; a stalled rsp_chan holds the
//  sequencer in its last state only when a second result is ready to go
// ----------------------------------------------------------------------------
module terrain_step_cost_3x3 import tsc_pkg::*; #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   tsc_req_if.sink               req_chan,
   tsc_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // column/row counter widths, and a common width for position compares
   localparam int AW    = $clog2(MAX_COLS);
   localparam int CW    = $clog2(MAX_COLS + 2);
   localparam int RW    = $clog2(MAX_ROWS + 3);
   localparam int CMP_A = (CW > RW) ? CW : RW;
   localparam int CMP_W = ((CMP_A > SIZE_W) ? CMP_A : SIZE_W) + 1;

   // configuration registers
   logic [LIMIT_W-1:0]  rise_limit_ff, drop_limit_ff;
   logic [WEIGHT_W-1:0] step_weight_ff;
   logic [SIZE_W-1:0]   cols_in_use_ff, rows_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_limit_ff  <= 16'd150;
         drop_limit_ff  <= 16'd150;
         step_weight_ff <= 16'd256;
         cols_in_use_ff <= 9'd256;
         rows_in_use_ff <= 9'd256;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RISE_LIMIT:  rise_limit_ff  <= csr_wdata;
            CSR_DROP_LIMIT:  drop_limit_ff  <= csr_wdata;
            CSR_STEP_WEIGHT: step_weight_ff <= csr_wdata;
            CSR_COLS_IN_USE: cols_in_use_ff <= csr_wdata[SIZE_W-1:0];
            CSR_ROWS_IN_USE: rows_in_use_ff <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // state
   state_type state_ff, state_in;
   logic [CW-1:0] col_ff;
   logic [RW-1:0] row_ff;
   item_ctl_type  ctl_ff;
   logic [AW-1:0] addr_ff;
   logic [ENTRY_W-1:0] bot_ff, top_ff, mid_ff, rd0_ff, rd1_ff;
   logic [ENTRY_W-1:0] win_ff [WIN_N];
   logic [WIN_IDX_W-1:0] k_ff;
   logic [HEIGHT_W-1:0]  rise_ff, drop_ff;
   logic                 blocked_ff;
   logic [SCALED_W-1:0]  scaled_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [HEIGHT_W-1:0]  div_rem_ff;
   logic [QUOT_W-1:0]    div_q_ff, qr_ff, qmax_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic                 div_sel_ff;
   logic                 rsp_valid_ff;
   rsp_payload_type      rsp_data_ff;

   // line stores: line 0 holds the previous row, line 1 the one above it
   logic [ENTRY_W-1:0] line0_mem [MAX_COLS];
   logic [ENTRY_W-1:0] line1_mem [MAX_COLS];

   // frame position of the incoming beat
   logic [CMP_W-1:0] ce, re, col_x, row_x, c1, r1, c, r, cn;
   logic             wrap, restart, early, req_fire;
   logic             emit, last, bot_valid;
   logic [CW-1:0]    col_nx;
   logic [RW-1:0]    row_nx;

   always_comb begin
      ce = (cols_in_use_ff == '0) ? CMP_W'(1)
         : ((CMP_W'(cols_in_use_ff) > CMP_W'(MAX_COLS)) ? CMP_W'(MAX_COLS)
            : CMP_W'(cols_in_use_ff));
      re = (rows_in_use_ff == '0) ? CMP_W'(1)
         : ((CMP_W'(rows_in_use_ff) > CMP_W'(MAX_ROWS)) ? CMP_W'(MAX_ROWS)
            : CMP_W'(rows_in_use_ff));
      col_x   = CMP_W'(col_ff);
      row_x   = CMP_W'(row_ff);
      // a column past the width wraps to the next row
      wrap    = col_x >= ce;
      c1      = wrap ? '0 : col_x;
      r1      = wrap ? row_x + CMP_W'(1) : row_x;
      // a position past the drain restarts the frame
      restart = (r1 > re + CMP_W'(1)) || ((r1 == re + CMP_W'(1)) && (c1 != '0));
      c       = restart ? '0 : c1;
      r       = restart ? '0 : r1;
      early   = (r < re) && (req_chan.data.operation == OP_FLUSH);
      bot_valid = (r < re) && (req_chan.data.operation == OP_CELL)
                  && req_chan.data.cell_occupied;
      emit    = (c != '0) ? (r >= CMP_W'(1)) : (r >= CMP_W'(2));
      last    = (c == '0) && (r >= CMP_W'(2)) && (r == re + CMP_W'(1));
      cn      = c + CMP_W'(1);
      if (early) begin
         col_nx = CW'(c);
         row_nx = RW'(r);
      end else if (last) begin
         col_nx = '0;
         row_nx = '0;
      end else if (cn >= ce) begin
         col_nx = '0;
         row_nx = RW'(r + CMP_W'(1));
      end else begin
         col_nx = CW'(cn);
         row_nx = RW'(r);
      end
   end

   // neighbor scan: one window entry per cycle against the center
   logic [HEIGHT_W-1:0] mine, nbr;
   logic                nbr_valid;
   logic [HEIGHT_W:0]   diff, ndiff;
   logic [ENTRY_W-1:0]  mid_val, top_val;

   always_comb begin
      mine      = win_ff[WIN_CENTER][HEIGHT_W-1:0];
      nbr       = win_ff[k_ff][HEIGHT_W-1:0];
      nbr_valid = win_ff[k_ff][HEIGHT_W] && (k_ff != WIN_IDX_W'(WIN_CENTER));
      diff      = {nbr[HEIGHT_W-1], nbr} - {mine[HEIGHT_W-1], mine};
      ndiff     = '0 - diff;
      mid_val   = ctl_ff.has_mid ? rd0_ff : '0;
      top_val   = ctl_ff.has_top ? rd1_ff : '0;
   end

   // shared divider: restoring, one quotient bit a cycle
   logic [LIMIT_W-1:0]  rl, dl, div_lim;
   logic [HEIGHT_W:0]   div_t;
   logic                div_bit;
   logic [HEIGHT_W-1:0] div_rem_nx;
   logic [QUOT_W-1:0]   div_q_nx;
   logic                blocked_now, rise_ge, drop_ge;

   always_comb begin
      rl          = (rise_limit_ff == '0) ? LIMIT_W'(1) : rise_limit_ff;
      dl          = (drop_limit_ff == '0) ? LIMIT_W'(1) : drop_limit_ff;
      div_lim     = div_sel_ff ? dl : rl;
      div_t       = {div_rem_ff, 1'b0};
      div_bit     = div_t >= {1'b0, div_lim};
      div_rem_nx  = div_bit ? HEIGHT_W'(div_t - {1'b0, div_lim}) : div_t[HEIGHT_W-1:0];
      div_q_nx    = {div_q_ff[QUOT_W-2:0], div_bit};
      blocked_now = (rise_ff > rl) || (drop_ff > dl);
      rise_ge     = rise_ff >= rl;
      drop_ge     = drop_ff >= dl;
   end

   logic out_free, done_go;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign done_go  = !ctl_ff.emit || out_free;
   assign req_fire = req_chan.valid && req_chan.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_fire && !early) state_in = ST_READ;
         ST_READ:  state_in = ST_SHIFT;
         ST_SHIFT: state_in = ctl_ff.emit ? ST_SCAN : ST_DONE;
         ST_SCAN:  if (k_ff == WIN_IDX_W'(WIN_N - 1)) state_in = ST_LIMIT;
         ST_LIMIT: begin
            if (blocked_now || !win_ff[WIN_CENTER][HEIGHT_W]) state_in = ST_DONE;
            else state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_sel_ff && (div_cnt_ff == '1)) state_in = ST_MULT;
         end
         ST_MULT:  state_in = ST_DONE;
         ST_DONE:  if (done_go) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_chan.ready = (state_ff == ST_IDLE);
      rsp_chan.valid = rsp_valid_ff;
      rsp_chan.data  = rsp_data_ff;
   end

   // line store access: read in its own cycle, written during the shift
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd0_ff <= line0_mem[addr_ff];
         rd1_ff <= line1_mem[addr_ff];
      end
      if (state_ff == ST_SHIFT) begin
         line0_mem[addr_ff] <= bot_ff;
         line1_mem[addr_ff] <= mid_val;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WIN_N; i++) win_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (req_fire) begin
            col_ff <= col_nx;
            row_ff <= row_nx;
            if (restart) begin
               for (int i = 0; i < WIN_N; i++) win_ff[i] <= '0;
            end
         end
         if (state_ff == ST_SHIFT) begin
            // column zero shifts in an empty column
            for (int i = 0; i < 3; i++) begin
               win_ff[3*i]     <= win_ff[3*i + 1];
               win_ff[3*i + 1] <= win_ff[3*i + 2];
            end
            win_ff[2] <= ctl_ff.first_col ? '0 : top_val;
            win_ff[5] <= ctl_ff.first_col ? '0 : mid_val;
            win_ff[8] <= ctl_ff.first_col ? '0 : bot_ff;
         end
         if ((state_ff == ST_DONE) && done_go) begin
            if (ctl_ff.last) begin
               for (int i = 0; i < WIN_N; i++) win_ff[i] <= '0;
            end else if (ctl_ff.first_col) begin
               // fresh window holding only the column just read
               for (int i = 0; i < WIN_N; i++) begin
                  if (i == 2) win_ff[i] <= top_ff;
                  else if (i == 5) win_ff[i] <= mid_ff;
                  else if (i == 8) win_ff[i] <= bot_ff;
                  else win_ff[i] <= '0;
               end
            end
         end
         if ((state_ff == ST_DONE) && ctl_ff.emit && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               addr_ff           <= c[AW-1:0];
               bot_ff            <= bot_valid ? {1'b1, req_chan.data.cell_height} : '0;
               ctl_ff.has_mid    <= r >= CMP_W'(1);
               ctl_ff.has_top    <= r >= CMP_W'(2);
               ctl_ff.first_col  <= c == '0;
               ctl_ff.emit       <= emit;
               ctl_ff.last       <= last;
            end
         end
         ST_SHIFT: begin
            top_ff  <= top_val;
            mid_ff  <= mid_val;
            k_ff    <= '0;
            rise_ff <= '0;
            drop_ff <= '0;
         end
         ST_SCAN: begin
            if (nbr_valid && !diff[HEIGHT_W] && (diff[HEIGHT_W-1:0] > rise_ff)) begin
               rise_ff <= diff[HEIGHT_W-1:0];
            end
            if (nbr_valid && diff[HEIGHT_W] && (ndiff[HEIGHT_W-1:0] > drop_ff)) begin
               drop_ff <= ndiff[HEIGHT_W-1:0];
            end
            k_ff <= k_ff + WIN_IDX_W'(1);
         end
         ST_LIMIT: begin
            blocked_ff <= blocked_now;
            scaled_ff  <= SCALED_W'(step_weight_ff)
                          * SCALED_W'(blocked_now ? BLOCK_FACTOR : PARTIAL_FACTOR);
            // integer part of rise/limit is 0 or 1 here
            div_q_ff   <= QUOT_W'(rise_ge);
            div_rem_ff <= rise_ge ? rise_ff - rl : rise_ff;
            div_cnt_ff <= '0;
            div_sel_ff <= 1'b0;
         end
         ST_DIV: begin
            div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == '1) begin
               if (!div_sel_ff) begin
                  qr_ff      <= div_q_nx;
                  div_sel_ff <= 1'b1;
                  div_q_ff   <= QUOT_W'(drop_ge);
                  div_rem_ff <= drop_ge ? drop_ff - dl : drop_ff;
               end else begin
                  qmax_ff <= (div_q_nx > qr_ff) ? div_q_nx : qr_ff;
               end
            end else begin
               div_q_ff   <= div_q_nx;
               div_rem_ff <= div_rem_nx;
            end
         end
         ST_MULT: begin
            prod_ff <= PROD_W'(scaled_ff) * PROD_W'(qmax_ff);
         end
         ST_DONE: begin
            if (ctl_ff.emit && out_free) begin
               rsp_data_ff.frame_end <= ctl_ff.last;
               if (!win_ff[WIN_CENTER][HEIGHT_W]) begin
                  rsp_data_ff.updated     <= 1'b0;
                  rsp_data_ff.step_rise   <= '0;
                  rsp_data_ff.blocked     <= 1'b0;
                  rsp_data_ff.cost_add    <= '0;
               end else begin
                  rsp_data_ff.updated     <= 1'b1;
                  rsp_data_ff.step_rise   <= rise_ff;
                  rsp_data_ff.blocked     <= blocked_ff;
                  rsp_data_ff.cost_add    <= blocked_ff ? scaled_ff[COST_W-1:0]
                                             : prod_ff[FRAC_W +: COST_W];
               end
            end
         end
         default: ;
      endcase
   end

endmodule

### verif/tsc_step_checker.sv
// ----------------------------------------------------------------------------
// tsc_step_checker
// watches the cell and result channels, grades every accepted cell beat with
// its own copy of the line stores and window, and compares each result beat
// field by field against the oldest expected grade
// ----------------------------------------------------------------------------
module tsc_step_checker import tsc_pkg::*; #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_payload_type       req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_payload_type       rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_count,
   output int                    graded_count,
   output int                    blocked_count
);

   logic [15:0] rise_lim, drop_lim, weight;
   logic [8:0]  cols_cfg, rows_cfg;
   logic [ENTRY_W-1:0] line_mem [2*MAX_COLS];
   logic [ENTRY_W-1:0] win [WIN_N];
   int unsigned col_pos, row_pos;
   rsp_payload_type grade_q[$];

   function automatic int signed height_of(logic [ENTRY_W-1:0] e);
      return int'($signed(e[HEIGHT_W-1:0]));
   endfunction

   function automatic rsp_payload_type grade_center();
      rsp_payload_type g;
      int signed mine, d, rise, drop;
      longint unsigned rl, dl, qr, qd, q;
      g = '0;
      if (!win[WIN_CENTER][HEIGHT_W]) return g;
      mine = height_of(win[WIN_CENTER]);
      rise = 0;
      drop = 0;
      for (int i = 0; i < WIN_N; i++) begin
         if (i != WIN_CENTER && win[i][HEIGHT_W]) begin
            d = height_of(win[i]) - mine;
            if (d > rise) rise = d;
            if (-d > drop) drop = -d;
         end
      end
      rl = (rise_lim == 0) ? 1 : rise_lim;
      dl = (drop_lim == 0) ? 1 : drop_lim;
      g.updated = 1'b1;
      g.step_rise = rise[15:0];
      if (longint'(rise) > rl || longint'(drop) > dl) begin
         g.blocked = 1'b1;
         g.cost_add = COST_W'(longint'(weight) * 255);
      end else begin
         qr = (longint'(rise) << 16) / rl;
         qd = (longint'(drop) << 16) / dl;
         q = (qr > qd) ? qr : qd;
         g.cost_add = COST_W'((longint'(weight) * 200 * q) >> 16);
      end
      return g;
   endfunction

   task automatic take_cell(req_payload_type it);
      int unsigned ce, re, r, c;
      logic [ENTRY_W-1:0] top, mid, bot;
      rsp_payload_type g;
      logic emit, last;
      ce = (cols_cfg == 0) ? 1 : cols_cfg;
      re = (rows_cfg == 0) ? 1 : rows_cfg;
      if (ce > MAX_COLS) ce = MAX_COLS;
      if (re > MAX_ROWS) re = MAX_ROWS;
      if (col_pos >= ce) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos > re + 1 || (row_pos == re + 1 && col_pos > 0)) begin
         row_pos = 0;
         col_pos = 0;
         foreach (win[i]) win[i] = '0;
      end
      r = row_pos;
      c = col_pos;
      if (r < re && it.operation == OP_FLUSH) return;
      bot = (r < re && it.cell_occupied) ? {1'b1, it.cell_height} : '0;
      mid = (r >= 1) ? line_mem[c] : '0;
      top = (r >= 2) ? line_mem[MAX_COLS + c] : '0;
      line_mem[MAX_COLS + c] = mid;
      line_mem[c] = bot;
      emit = 0;
      last = 0;
      // slide the window one column left, new column on the right
      for (int k = 0; k < 3; k++) begin
         win[k*3] = win[k*3+1];
         win[k*3+1] = win[k*3+2];
      end
      win[2] = (c >= 1) ? top : '0;
      win[5] = (c >= 1) ? mid : '0;
      win[8] = (c >= 1) ? bot : '0;
      if (c >= 1) begin
         if (r >= 1) begin
            g = grade_center();
            emit = 1;
         end
      end else begin
         if (r >= 2) begin
            g = grade_center();
            emit = 1;
            last = (r == re + 1);
         end
         foreach (win[i]) win[i] = '0;
         win[2] = top;
         win[5] = mid;
         win[8] = bot;
      end
      if (last) begin
         g.frame_end = 1'b1;
         row_pos = 0;
         col_pos = 0;
         foreach (win[i]) win[i] = '0;
      end else begin
         col_pos = c + 1;
         if (col_pos >= ce) begin
            col_pos = 0;
            row_pos = r + 1;
         end
      end
      if (emit) grade_q.push_back(g);
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rise_lim <= 16'd150;
         drop_lim <= 16'd150;
         weight   <= 16'd256;
         cols_cfg <= 9'd256;
         rows_cfg <= 9'd256;
         col_pos = 0;
         row_pos = 0;
         foreach (win[i]) win[i] = '0;
         grade_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (grade_q.size() == 0) begin
               $display("%0t: unexpected result beat %p", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = grade_q.pop_front();
               if (want !== rsp_data) begin
                  $display("%0t: result beat mismatch: expected %p, actual %p",
                           $time, want, rsp_data);
                  fail_count <= fail_count + 1;
               end
               graded_count <= graded_count + want.updated;
               blocked_count <= blocked_count + want.blocked;
            end
         end
         if (req_valid && req_ready) take_cell(req_data);
         if (csr_we) begin
            case (csr_index)
               CSR_RISE_LIMIT:  rise_lim <= csr_wdata;
               CSR_DROP_LIMIT:  drop_lim <= csr_wdata;
               CSR_STEP_WEIGHT: weight   <= csr_wdata;
               CSR_COLS_IN_USE: cols_cfg <= csr_wdata[8:0];
               CSR_ROWS_IN_USE: rows_cfg <= csr_wdata[8:0];
               default: ;
            endcase
         end
      end
      pending_count <= grade_q.size();
   end

endmodule

### verif/tb_terrain_step_cost_3x3.sv
// ----------------------------------------------------------------------------
// tb_terrain_step_cost_3x3
// streams small elevation frames with random heights and occupancy under a
// range of limit, weight and grid-size settings, with bursty cell traffic and
// result back-pressure; a side checker grades each cell and compares
// ----------------------------------------------------------------------------
module tb_terrain_step_cost_3x3;
   import tsc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   tsc_req_if req_chan ();
   tsc_rsp_if rsp_chan ();

   int fail_count, pending_count, graded_count, blocked_count;
   int cells_sent = 0;
   int frames_sent = 0;
   bit hold_off_req = 1'b0;      // request a long receiver stall
   int unsigned cur_cols = 256;
   int unsigned cur_rows = 256;
   logic signed [15:0] base_height;

   terrain_step_cost_3x3 u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tsc_step_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_data      (req_chan.data),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_data      (rsp_chan.data),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .graded_count  (graded_count),
      .blocked_count (blocked_count)
   );

   always #5 clock = ~clock;

   // watchdog: worst case per cell plus stalls stays far below this
   initial begin
      #20000000;
      $display("timeout");
      $display("terrain_step_cost_3x3: mismatch");
      $finish;
   end

   // result side: own stall pattern plus one long hold-off on request
   initial begin
      int stall_len;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_chan.ready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_off_req = 1'b0;
         end
         case ($urandom_range(0, 3))
            0: stall_len = $urandom_range(1, 60);   // stall
            default: stall_len = 0;
         endcase
         if (stall_len > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall_len) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 80)) @(negedge clock);
      end
   end

   // one beat on the cell channel, then a random gap at burst ends
   task automatic send_beat(logic op, logic [15:0] h, logic occ, bit gap_ok);
      req_chan.valid <= 1'b1;
      req_chan.data  <= '{operation: op, cell_height: h, cell_occupied: occ};
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      cells_sent++;
      if (gap_ok && $urandom_range(0, 7) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(negedge clock);
      end
   endtask

   // one write strobe, then write enable low again so writes never overlap
   task automatic write_reg(csr_index_type idx, logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   // quiet point: wait for all grades, then let the sequencer settle
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   // random height near a base so many cells land under the limits
   function automatic logic [15:0] pick_height();
      case ($urandom_range(0, 5))
         0: return 16'($urandom);
         1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         default: return 16'(base_height + $signed(11'($urandom_range(0, 600))) - 300);
      endcase
   endfunction

   // a whole frame: all cells, optional early flushes, then the drain
   task automatic run_frame(int occ_pct, bit noisy);
      int n;
      n = cur_cols * cur_rows;
      base_height = 16'($urandom);
      for (int i = 0; i < n; i++) begin
         // early flush is ignored by the block
         if (noisy && $urandom_range(0, 9) == 0)
            send_beat(OP_FLUSH, 16'($urandom), 1'($urandom), 1);
         send_beat(OP_CELL, pick_height(), $urandom_range(1, 100) <= occ_pct, 1);
      end
      // drain: flushes, sometimes cell beats whose data is ignored
      for (int i = 0; i <= cur_cols; i++) begin
         if (noisy && $urandom_range(0, 3) == 0)
            send_beat(OP_CELL, 16'($urandom), 1'b1, 1);
         else
            send_beat(OP_FLUSH, 16'($urandom), 1'($urandom), 1);
      end
      frames_sent++;
   endtask

   task automatic set_size(int unsigned c, int unsigned r);
      write_reg(CSR_COLS_IN_USE, 16'(c));
      write_reg(CSR_ROWS_IN_USE, 16'(r));
      cur_cols = c;
      cur_rows = r;
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: tiny frame at reset limits, extremes of height and occupancy
      set_size(3, 2);
      base_height = 0;
      send_beat(OP_FLUSH, 16'hFFFF, 1'b1, 0);   // early flush, ignored
      send_beat(OP_CELL, 16'h7FFF, 1'b1, 0);
      send_beat(OP_CELL, 16'h8000, 1'b1, 0);
      send_beat(OP_CELL, 16'h0000, 1'b0, 0);
      send_beat(OP_CELL, 16'd100, 1'b1, 0);
      send_beat(OP_CELL, 16'd250, 1'b1, 0);
      send_beat(OP_CELL, 16'd100, 1'b1, 0);
      for (int i = 0; i < 4; i++) send_beat(OP_FLUSH, 16'h0000, 1'b0, 0);
      wait_drained();

      // directed: extreme limits and weights, exact-limit steps
      write_reg(CSR_RISE_LIMIT, 16'hFFFF);
      write_reg(CSR_DROP_LIMIT, 16'd0);
      write_reg(CSR_STEP_WEIGHT, 16'hFFFF);
      set_size(3, 3);
      send_beat(OP_CELL, 16'd0, 1'b1, 0);
      send_beat(OP_CELL, 16'd1, 1'b1, 0);
      send_beat(OP_CELL, 16'd0, 1'b1, 0);
      send_beat(OP_CELL, 16'hFFFF, 1'b1, 0);
      send_beat(OP_CELL, 16'd0, 1'b1, 0);
      send_beat(OP_CELL, 16'h8000, 1'b1, 0);
      send_beat(OP_CELL, 16'd0, 1'b1, 0);
      send_beat(OP_CELL, 16'd2, 1'b0, 0);
      send_beat(OP_CELL, 16'h7FFF, 1'b1, 0);
      for (int i = 0; i < 4; i++) send_beat(OP_FLUSH, 16'h0000, 1'b0, 0);
      wait_drained();

      // one-by-one and out-of-range sizes (zero acts as one, above max saturates)
      write_reg(CSR_STEP_WEIGHT, 16'd0);
      set_size(0, 1);
      cur_cols = 1;
      run_frame(100, 0);
      wait_drained();
      write_reg(CSR_STEP_WEIGHT, 16'd256);
      set_size(1, 0);
      cur_rows = 1;
      run_frame(70, 0);
      wait_drained();
      set_size(511, 1);
      cur_cols = 256;
      run_frame(80, 1);
      wait_drained();

      // long receiver hold-off while cells keep coming, then full drain
      hold_off_req = 1'b1;
      set_size(8, 4);
      run_frame(90, 0);
      wait_drained();

      // random phases over settings
      while (cells_sent < 700) begin
         case ($urandom_range(0, 3))
            0: write_reg(CSR_RISE_LIMIT, 16'($urandom_range(1, 1000)));
            1: write_reg(CSR_DROP_LIMIT, 16'($urandom_range(1, 1000)));
            2: write_reg(CSR_STEP_WEIGHT, 16'($urandom));
            default: write_reg(CSR_RISE_LIMIT, 16'($urandom));
         endcase
         if ($urandom_range(0, 1)) write_reg(CSR_DROP_LIMIT, 16'($urandom));
         set_size($urandom_range(1, 9), $urandom_range(1, 6));
         repeat ($urandom_range(1, 3)) run_frame($urandom_range(30, 100),
                                                  $urandom_range(0, 3) == 0);
         wait_drained();
      end

      // settle past the last grade
      while (pending_count != 0) @(negedge clock);
      repeat (100) @(negedge clock);

      $display("covered %0d cell beats in %0d frames; %0d occupied grades, %0d blocked",
               cells_sent, frames_sent, graded_count, blocked_count);
      if (fail_count == 0) begin
         $display("terrain_step_cost_3x3: match");
      end else begin
         $display("terrain_step_cost_3x3: mismatch");
      end
      $finish;
   end

endmodule
